[hw/rtl/stop_wait_arq_receiver_top_assert.svh]
// Assertion macros used by the stop-and-wait ARQ receiver RTL.
`ifndef STOP_WAIT_ARQ_RECEIVER_TOP_ASSERT_SVH
`define STOP_WAIT_ARQ_RECEIVER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define SWARQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swarq assertion failed");

// Next-cycle implication, disabled while in reset.
`define SWARQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swarq assertion failed");

`endif

[hw/rtl/swarq_pkg.sv]
// Types, constants and helper functions of the stop-and-wait ARQ receiver.
`default_nettype none

package swarq_pkg;

    // Packet type codes
    localparam logic [7:0] TYPE_ACK     = 8'h02;
    localparam logic [7:0] TYPE_PSH     = 8'h08;
    localparam logic [7:0] TYPE_PSH_OVE = 8'h18;

    // Header layout and word counter limits
    localparam int          HEADER_WORDS = 3;
    localparam logic [12:0] IDX_LENGTH   = 13'd0;
    localparam logic [12:0] IDX_TYPESEQ  = 13'd2;
    localparam logic [12:0] INDEX_CAP    = 13'h1FFF;

    // ACK frame length field: 1024-byte frame minus 6 header bytes
    localparam logic [15:0] ACK_LENGTH = 16'd1018;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        VERDICT_DATA   = 2'd0,
        VERDICT_FINAL  = 2'd1,
        VERDICT_DUP    = 2'd2,
        VERDICT_REJECT = 2'd3
    } verdict_t;

    typedef struct packed {
        logic [15:0] word;
        logic        last;
    } in_item_t;

    typedef struct packed {
        verdict_t    verdict;
        logic        send_ack;
        logic [7:0]  ack_seq;
        logic [15:0] ack_checksum;
    } out_item_t;

    // Packet summary handed from front to back
    typedef struct packed {
        logic       ok;
        logic       is_final;
        logic [7:0] seq;
    } pkt_rec_t;

    // One's-complement add with end-around carry
    function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s[16])
            return s[15:0] + 16'd1;
        return s[15:0];
    endfunction

    // Checksum of the ACK header with zero padding
    function automatic logic [15:0] ack_checksum(input logic [7:0] seq);
        logic [15:0] s;
        s = fold_add(ACK_LENGTH, {seq, TYPE_ACK});
        return ~s;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/swarq_front.sv]
// Front end: tracks packet words, checksum and header, and classifies each packet.
`default_nettype none

module swarq_front #(
    parameter int MAX_PAYLOAD = 8192
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire swarq_pkg::in_item_t in_data,
    input  wire logic               q_full,
    output logic                    q_push,
    output swarq_pkg::pkt_rec_t     q_wdata
);
    import swarq_pkg::*;

    localparam logic [16:0] MAX_LEN = 17'(MAX_PAYLOAD);

    logic [12:0] idx_reg, idx_next;
    logic [15:0] len_reg, len_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  seq_reg, seq_next;
    logic [15:0] sum_reg, sum_next;

    logic        accept;
    logic [15:0] len_cur;
    logic [7:0]  type_cur;
    logic [7:0]  seq_cur;
    logic [16:0] half_len;
    logic [16:0] needed;
    logic [16:0] idx_ext;
    logic        in_range;
    logic        mask_odd;
    logic [15:0] sum_word;
    logic [15:0] sum_cur;
    logic        complete;
    logic        fits;
    logic        type_ok;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // Bypass header fields that arrive in this word
    assign len_cur  = (idx_reg == IDX_LENGTH)  ? in_data.word : len_reg;
    assign type_cur = (idx_reg == IDX_TYPESEQ) ? in_data.word[7:0] : type_reg;
    assign seq_cur  = (idx_reg == IDX_TYPESEQ) ? in_data.word[15:8] : seq_reg;

    // Words the packet needs: header plus rounded-up payload words
    assign half_len = ({1'b0, len_cur} + 17'd1) >> 1;
    assign needed   = 17'(HEADER_WORDS) + half_len;
    assign idx_ext  = {4'd0, idx_reg};

    // Sum the word if it lies inside the stated length; zero the pad byte
    assign in_range = (idx_ext < needed) && (idx_reg != INDEX_CAP);
    assign mask_odd = (idx_ext >= 17'(HEADER_WORDS)) && (idx_ext == needed - 17'd1)
                      && len_cur[0];
    assign sum_word = mask_odd ? {8'h00, in_data.word[7:0]} : in_data.word;
    assign sum_cur  = in_range ? fold_add(sum_reg, sum_word) : sum_reg;

    // Classify on the final word
    assign complete = (idx_ext + 17'd1 >= needed) && (needed <= {4'd0, INDEX_CAP});
    assign fits     = {1'b0, len_cur} <= MAX_LEN;
    assign type_ok  = (type_cur == TYPE_PSH) || (type_cur == TYPE_PSH_OVE);

    assign q_push           = accept && in_data.last;
    assign q_wdata.ok       = complete && fits && (sum_cur == 16'hFFFF) && type_ok;
    assign q_wdata.is_final = (type_cur == TYPE_PSH_OVE);
    assign q_wdata.seq      = seq_cur;

    // Advance packet state, clear it after the final word
    always_comb
    begin
        idx_next  = idx_reg;
        len_next  = len_reg;
        type_next = type_reg;
        seq_next  = seq_reg;
        sum_next  = sum_reg;
        if (accept)
        begin
            if (in_data.last)
            begin
                idx_next  = '0;
                len_next  = '0;
                type_next = '0;
                seq_next  = '0;
                sum_next  = '0;
            end
            else
            begin
                idx_next  = (idx_reg == INDEX_CAP) ? idx_reg : idx_reg + 13'd1;
                len_next  = len_cur;
                type_next = type_cur;
                seq_next  = seq_cur;
                sum_next  = sum_cur;
            end
        end
    end

    // Hold packet state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            len_reg  <= '0;
            type_reg <= '0;
            seq_reg  <= '0;
            sum_reg  <= '0;
        end
        else
        begin
            idx_reg  <= idx_next;
            len_reg  <= len_next;
            type_reg <= type_next;
            seq_reg  <= seq_next;
            sum_reg  <= sum_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/swarq_queue.sv]
// Short queue of packet summaries between front and back.
`default_nettype none

`include "stop_wait_arq_receiver_top_assert.svh"

module swarq_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire swarq_pkg::pkt_rec_t wdata,
    input  wire logic                pop,
    output logic                     full,
    output logic                     not_empty,
    output swarq_pkg::pkt_rec_t      rdata
);
    import swarq_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

    pkt_rec_t         entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full      = (cnt_reg == DEPTH_CNT);
    assign not_empty = (cnt_reg != '0);
    assign rdata     = entry_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store pushed entries
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= wdata;
    end

    // Overflow, underflow and not-empty after a push
    `SWARQ_ASSERT_NOW(a_no_overflow, clk, rst_n, push, !full)
    `SWARQ_ASSERT_NOW(a_no_underflow, clk, rst_n, pop, not_empty)
    `SWARQ_ASSERT_NEXT(a_push_not_empty, clk, rst_n, push, not_empty)

endmodule

`default_nettype wire

[hw/rtl/swarq_back.sv]
// Back end: checks sequence against the last ACK and registers the verdict.
`default_nettype none

module swarq_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [7:0]          cfg_wdata,
    input  wire logic                q_not_empty,
    input  wire swarq_pkg::pkt_rec_t q_rdata,
    output logic                     q_pop,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output swarq_pkg::out_item_t     out_data
);
    import swarq_pkg::*;

    logic [7:0] last_ack_reg, last_ack_next;
    logic       out_valid_reg, out_valid_next;
    out_item_t  out_data_reg;
    out_item_t  result;
    logic [7:0] seq_plus;
    logic       take;

    assign take      = q_not_empty && (!out_valid_reg || out_ready);
    assign q_pop     = take;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign seq_plus  = last_ack_reg + 8'd1;

    // Decide accept, duplicate or reject
    always_comb
    begin
        last_ack_next       = last_ack_reg;
        result.verdict      = VERDICT_REJECT;
        result.send_ack     = 1'b1;
        result.ack_seq      = last_ack_reg;
        result.ack_checksum = ack_checksum(last_ack_reg);
        if (q_rdata.ok && (q_rdata.seq == seq_plus))
        begin
            last_ack_next       = seq_plus;
            result.verdict      = q_rdata.is_final ? VERDICT_FINAL : VERDICT_DATA;
            result.ack_seq      = seq_plus;
            result.ack_checksum = ack_checksum(seq_plus);
        end
        else if (q_rdata.ok && (q_rdata.seq == last_ack_reg))
        begin
            result.verdict      = VERDICT_DUP;
            result.send_ack     = 1'b0;
            result.ack_seq      = '0;
            result.ack_checksum = '0;
        end
    end

    // Hold output valid until the transaction completes
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_ack_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                last_ack_reg <= cfg_wdata;
            else if (take)
                last_ack_reg <= last_ack_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (take)
            out_data_reg <= result;
    end

endmodule

`default_nettype wire

[hw/rtl/stop_wait_arq_receiver_top.sv]
// Top level of the stop-and-wait ARQ receiver: front, queue and back.
// Throughput: one packet word per cycle; in_ready drops only while the queue is full.
// After the final word's transaction, a verdict is registered first in the queue entry and
// then in the result register, where it is valid once the output is free.
// Reset clears packet state, empties the queue and loads last_ack with zero.
// No clearing pass: in_ready is high as soon as reset is released.
`default_nettype none

module stop_wait_arq_receiver_top #(
    parameter int MAX_PAYLOAD = 8192
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire swarq_pkg::in_item_t  in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output swarq_pkg::out_item_t      out_data,
    input  wire logic                 cfg_we,
    input  wire logic [7:0]           cfg_wdata
);
    import swarq_pkg::*;

    logic     q_push;
    logic     q_pop;
    logic     q_full;
    logic     q_not_empty;
    pkt_rec_t q_wdata;
    pkt_rec_t q_rdata;

    // Accept and classify words
    swarq_front #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_wdata  (q_wdata)
    );

    // Decouple front and back
    swarq_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .wdata     (q_wdata),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .rdata     (q_rdata)
    );

    // Sequence check and result
    swarq_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .q_not_empty (q_not_empty),
        .q_rdata     (q_rdata),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

endmodule

`default_nettype wire

[sim/tb_stop_wait_arq_receiver_top.sv]
// Testbench of the stop-and-wait ARQ receiver: directed packet table, then random traffic.
`timescale 1ns / 1ps

module tb_stop_wait_arq_receiver_top;
    import swarq_pkg::*;

    localparam int          MAX_PAYLOAD  = 8192;
    localparam int          CYCLE_LIMIT  = 600000;
    localparam int          PHASE_WORDS  = 170;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          IDLE_PCT     = 21;
    localparam int          NUM_PHASES   = 6;

    typedef enum {PK_GOOD, PK_BAD_SUM, PK_CUT, PK_EXTRA, PK_NOISE} pkt_kind_t;
    typedef enum {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_t;

    typedef struct {
        pkt_kind_t  kind;
        int         len;
        logic [7:0] ptype;
        logic [7:0] seq;
        fill_t      fill;
        int         cut_at;
        int         extra;
        bit         has_exp;
        out_item_t  exp;
    } pkt_spec_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;
    logic      cfg_we = 1'b0;
    logic [7:0] cfg_wdata = 8'd0;

    // Predictor state
    logic [7:0]  ack_state;
    logic [15:0] sum_acc;
    int unsigned widx;
    logic [15:0] len_acc;
    logic [7:0]  type_acc;
    logic [7:0]  seq_acc;

    out_item_t verdict_q[$];
    bit        typed_pending;
    out_item_t typed_verdict;
    bit        calm;

    int errors;
    int words_sent;
    int packets_sent;
    int verdicts_seen;
    int n_accept;
    int n_dup;
    int n_reject;
    int cycle_count;

    // Directed packets from reset; typed verdicts where they follow at a glance
    pkt_spec_t directed_rows [16] = '{
        '{PK_GOOD,    0, TYPE_PSH,     8'd1,   FILL_RANDOM, 0, 0, 1'b1,
          '{VERDICT_DATA,   1'b1, 8'd1, 16'hFB03}},
        '{PK_GOOD,    4, TYPE_PSH,     8'd1,   FILL_RANDOM, 0, 0, 1'b1,
          '{VERDICT_DUP,    1'b0, 8'd0, 16'h0000}},
        '{PK_GOOD,    3, TYPE_PSH_OVE, 8'd2,   FILL_ONES,   0, 0, 1'b1,
          '{VERDICT_FINAL,  1'b1, 8'd2, 16'hFA03}},
        '{PK_GOOD,    1, TYPE_PSH,     8'd3,   FILL_RANDOM, 0, 0, 1'b0, '0},
        '{PK_BAD_SUM, 2, TYPE_PSH,     8'd4,   FILL_RANDOM, 0, 0, 1'b1,
          '{VERDICT_REJECT, 1'b1, 8'd3, 16'hF903}},
        '{PK_GOOD,    0, TYPE_ACK,     8'd4,   FILL_RANDOM, 0, 0, 1'b1,
          '{VERDICT_REJECT, 1'b1, 8'd3, 16'hF903}},
        '{PK_GOOD,    2, 8'hFF,        8'd4,   FILL_ONES,   0, 0, 1'b0, '0},
        '{PK_GOOD,    0, TYPE_PSH,     8'h80,  FILL_RANDOM, 0, 0, 1'b1,
          '{VERDICT_REJECT, 1'b1, 8'd3, 16'hF903}},
        '{PK_CUT,     65535, TYPE_PSH, 8'd4,   FILL_RANDOM, 0, 0, 1'b1,
          '{VERDICT_REJECT, 1'b1, 8'd3, 16'hF903}},
        '{PK_CUT,     6, TYPE_PSH,     8'd4,   FILL_RANDOM, 3, 0, 1'b0, '0},
        '{PK_CUT,     MAX_PAYLOAD + 1, TYPE_PSH, 8'd4, FILL_RANDOM, 5, 0, 1'b0, '0},
        '{PK_EXTRA,   2, TYPE_PSH,     8'd4,   FILL_RANDOM, 0, 2, 1'b0, '0},
        '{PK_GOOD,    20, TYPE_PSH_OVE, 8'd5,  FILL_ONES,   0, 0, 1'b0, '0},
        '{PK_GOOD,    8, TYPE_PSH,     8'd6,   FILL_ZEROS,  0, 0, 1'b0, '0},
        '{PK_NOISE,   0, 8'd0,         8'd0,   FILL_RANDOM, 2, 0, 1'b0, '0},
        '{PK_GOOD,    5, TYPE_PSH,     8'd6,   FILL_RANDOM, 0, 0, 1'b0, '0}
    };

    stop_wait_arq_receiver_top #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Clock: 20 ns period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // One's-complement add with end-around carry
    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s[16])
            s = {1'b0, s[15:0]} + 17'd1;
        return s[15:0];
    endfunction

    // Checksum carried by an ACK for the given sequence
    function automatic logic [15:0] ack_sum_for(input logic [7:0] seq);
        logic [15:0] s;
        s = ones_add(16'd0, ACK_LENGTH);
        s = ones_add(s, 16'd0);
        s = ones_add(s, {seq, TYPE_ACK});
        return ~s;
    endfunction

    // Clear the per-packet predictor state
    function automatic void clear_packet_state();
        sum_acc  = '0;
        widx     = 0;
        len_acc  = '0;
        type_acc = '0;
        seq_acc  = '0;
    endfunction

    // Advance the predictor by one word; return 1 when a verdict is due
    function automatic bit predict_verdict(input in_item_t it, output out_item_t res);
        int unsigned i;
        int unsigned needed;
        logic [15:0] v;
        bit          complete;
        bit          fits;
        bit          ok;
        bit          type_ok;
        bit          next_ok;
        bit          dup_ok;
        i = widx;
        res = '0;
        if (i == 0)
            len_acc = it.word;
        else if (i == 2)
        begin
            type_acc = it.word[7:0];
            seq_acc  = it.word[15:8];
        end
        needed = HEADER_WORDS + ((32'(len_acc) + 1) >> 1);
        if (i < needed && i < 32'(INDEX_CAP))
        begin
            v = it.word;
            // Drop the pad byte of an odd final payload word
            if (i >= HEADER_WORDS && i == needed - 1 && len_acc[0])
                v = v & 16'h00FF;
            sum_acc = ones_add(sum_acc, v);
        end
        if (i < 32'(INDEX_CAP))
            widx = i + 1;
        if (!it.last)
            return 1'b0;
        complete = (i + 1 >= needed) && (needed <= 32'(INDEX_CAP));
        fits     = 32'(len_acc) <= MAX_PAYLOAD;
        ok       = complete && fits && (sum_acc == 16'hFFFF);
        type_ok  = (type_acc == TYPE_PSH) || (type_acc == TYPE_PSH_OVE);
        next_ok  = seq_acc == ack_state + 8'd1;
        dup_ok   = seq_acc == ack_state;
        if (ok && type_ok && next_ok)
        begin
            ack_state        = ack_state + 8'd1;
            res.verdict      = (type_acc == TYPE_PSH) ? VERDICT_DATA : VERDICT_FINAL;
            res.send_ack     = 1'b1;
            res.ack_seq      = ack_state;
            res.ack_checksum = ack_sum_for(ack_state);
        end
        else if (ok && type_ok && dup_ok)
        begin
            res.verdict = VERDICT_DUP;
        end
        else
        begin
            res.verdict      = VERDICT_REJECT;
            res.send_ack     = 1'b1;
            res.ack_seq      = ack_state;
            res.ack_checksum = ack_sum_for(ack_state);
        end
        clear_packet_state();
        return 1'b1;
    endfunction

    // Drive one word and wait for its transaction; record the verdict it causes
    task automatic send_word(input in_item_t it);
        out_item_t res;
        // Idle one cycle at a time, each with the idle chance
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (predict_verdict(it, res))
        begin
            verdict_q.push_back(typed_pending ? typed_verdict : res);
            typed_pending = 1'b0;
        end
        words_sent++;
    endtask

    // Build one packet from its description and send it word by word
    task automatic send_packet(input pkt_spec_t spec);
        logic [15:0] words[$];
        logic [15:0] s;
        logic [15:0] pw;
        int          needed;
        in_item_t    it;
        needed = HEADER_WORDS + (spec.len + 1) / 2;
        if (spec.kind == PK_NOISE)
        begin
            for (int k = 0; k <= spec.cut_at; k++)
                words.push_back(16'($urandom()));
        end
        else
        begin
            words.push_back(16'(spec.len));
            words.push_back(16'd0);
            words.push_back({spec.seq, spec.ptype});
            s = ones_add(16'(spec.len), {spec.seq, spec.ptype});
            for (int k = HEADER_WORDS; k < needed; k++)
            begin
                case (spec.fill)
                    FILL_ONES:  pw = 16'hFFFF;
                    FILL_ZEROS: pw = 16'h0000;
                    default:    pw = 16'($urandom());
                endcase
                words.push_back(pw);
                if (k == needed - 1 && spec.len[0])
                    pw = pw & 16'h00FF;
                s = ones_add(s, pw);
            end
            words[1] = ~s;
            if (spec.kind == PK_BAD_SUM)
                words[1] = words[1] ^ 16'($urandom_range(1, 16'hFFFE));
            if (spec.kind == PK_EXTRA)
                for (int k = 0; k < spec.extra; k++)
                    words.push_back(16'($urandom()));
            if (spec.kind == PK_CUT)
                while (words.size() > spec.cut_at + 1)
                    void'(words.pop_back());
        end
        typed_pending = spec.has_exp;
        typed_verdict = spec.exp;
        for (int k = 0; k < words.size(); k++)
        begin
            it.word = words[k];
            it.last = (k == words.size() - 1);
            send_word(it);
        end
        packets_sent++;
    endtask

    // Pick a random packet; mostly in-order data, the rest broken or noise
    task automatic random_packet();
        pkt_spec_t spec;
        int        r;
        int        needed;
        r = $urandom_range(0, 99);
        spec = '{PK_GOOD, 0, TYPE_PSH, ack_state + 8'd1, FILL_RANDOM, 0, 0, 1'b0, '0};
        case ($urandom_range(0, 19))
            0:       spec.len = $urandom_range(81, 300);
            1, 2, 3, 4, 5:
                     spec.len = $urandom_range(13, 80);
            default: spec.len = $urandom_range(0, 12);
        endcase
        if ($urandom_range(0, 1))
            spec.ptype = TYPE_PSH_OVE;
        if ($urandom_range(0, 15) == 0)
            spec.fill = ($urandom_range(0, 1)) ? FILL_ONES : FILL_ZEROS;
        needed = HEADER_WORDS + (spec.len + 1) / 2;
        if (r < 55)
            ;
        else if (r < 63)
            spec.seq = ack_state;
        else if (r < 68)
            spec.kind = PK_BAD_SUM;
        else if (r < 73)
            spec.ptype = 8'($urandom());
        else if (r < 78)
            spec.seq = 8'($urandom());
        else if (r < 84)
        begin
            spec.kind   = PK_CUT;
            spec.cut_at = $urandom_range(0, needed - 2);
        end
        else if (r < 90)
        begin
            spec.kind  = PK_EXTRA;
            spec.extra = $urandom_range(1, 3);
        end
        else if (r < 93)
        begin
            // Oversized length, cut short after a few words
            spec.kind   = PK_CUT;
            spec.len    = $urandom_range(MAX_PAYLOAD + 1, 65535);
            spec.cut_at = $urandom_range(3, 10);
        end
        else
        begin
            spec.kind   = PK_NOISE;
            spec.cut_at = $urandom_range(0, 5);
        end
        send_packet(spec);
    endtask

    // Hold the input idle until every verdict is in and the pipeline is empty
    task automatic drain();
        in_valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Load start_seq while idle
    task automatic write_start_seq(input logic [7:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        ack_state = value;
    endtask

    // Drive the output side: stall at random except during the calm stretch
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Compare each verdict transaction with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            verdicts_seen++;
            case (out_data.verdict)
                VERDICT_DATA, VERDICT_FINAL: n_accept++;
                VERDICT_DUP:                 n_dup++;
                default:                     n_reject++;
            endcase
            if (verdict_q.size() == 0)
            begin
                $error("verdict with none expected: %0d", out_data.verdict);
                errors++;
            end
            else
            begin
                if (out_data.verdict != verdict_q[0].verdict)
                begin
                    $error("verdict: expected %0d, got %0d",
                           verdict_q[0].verdict, out_data.verdict);
                    errors++;
                end
                if (out_data.send_ack != verdict_q[0].send_ack)
                begin
                    $error("send_ack: expected %0d, got %0d",
                           verdict_q[0].send_ack, out_data.send_ack);
                    errors++;
                end
                if (out_data.ack_seq != verdict_q[0].ack_seq)
                begin
                    $error("ack_seq: expected %0d, got %0d",
                           verdict_q[0].ack_seq, out_data.ack_seq);
                    errors++;
                end
                if (out_data.ack_checksum != verdict_q[0].ack_checksum)
                begin
                    $error("ack_checksum: expected %h, got %h",
                           verdict_q[0].ack_checksum, out_data.ack_checksum);
                    errors++;
                end
                void'(verdict_q.pop_front());
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d verdicts pending",
                     cycle_count, verdict_q.size());
            $display("simulation failed");
            $finish;
        end
    end

    // Main sequence
    initial
    begin
        logic [7:0] phase_seq [NUM_PHASES];
        int         phase_start;
        errors        = 0;
        words_sent    = 0;
        packets_sent  = 0;
        verdicts_seen = 0;
        n_accept      = 0;
        n_dup         = 0;
        n_reject      = 0;
        cycle_count   = 0;
        calm          = 1'b0;
        typed_pending = 1'b0;
        ack_state     = '0;
        clear_packet_state();
        phase_seq = '{8'd255, 8'd0, 8'd128, 8'($urandom()), 8'd254, 8'd1};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table from the reset state
        foreach (directed_rows[k])
            send_packet(directed_rows[k]);

        // Random traffic over several start sequences
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_start_seq(phase_seq[p]);
            phase_start = words_sent;
            while (words_sent - phase_start < PHASE_WORDS)
            begin
                // Hold both sides busy through one stretch
                calm = (p == 2);
                random_packet();
            end
            calm = 1'b0;
        end

        drain();
        $display("covered %0d packets in %0d words over %0d start sequences",
                 packets_sent, words_sent, NUM_PHASES);
        $display("checked %0d verdicts: %0d accepted, %0d duplicate, %0d rejected",
                 verdicts_seen, n_accept, n_dup, n_reject);
        if (errors == 0 && verdict_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
